// File: rtl/ssfd_pkg.sv
// Shared types, constants and the segment decode table of the seven-segment frame decoder.
package ssfd_pkg;

  localparam int unsigned MAX_BYTES = 8;
  localparam int unsigned CNT_W     = 4;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [63:0] display_text;
    logic [63:0] raw_frame;
    logic [2:0]  display_class;
    logic [9:0]  temperature;
    logic        temp_valid;
    logic        temp_changed;
    logic        class_changed;
    logic        frame_changed;
    logic [3:0]  match_count;
    logic        temp_out_of_range;
    logic        marker_present;
  } out_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_WALK,
    B_FINISH
  } back_state_t;

  localparam logic [1:0] REG_FRAME_GAP = 2'd0;
  localparam logic [1:0] REG_TEMP_LOW  = 2'd1;
  localparam logic [1:0] REG_TEMP_HIGH = 2'd2;

  localparam logic [2:0] CLASS_TEMP    = 3'd0;
  localparam logic [2:0] CLASS_OH      = 3'd1;
  localparam logic [2:0] CLASS_ICE     = 3'd2;
  localparam logic [2:0] CLASS_STARTUP = 3'd3;
  localparam logic [2:0] CLASS_BLANK   = 3'd4;
  localparam logic [2:0] CLASS_UNKNOWN = 3'd5;
  localparam logic [2:0] CLASS_NONE    = 3'd7;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_QUERY = 8'h3F;

  localparam logic [7:0] SEG_MASK  = 8'h7F;
  localparam logic [6:0] SEG_ONE   = 7'h30;
  localparam logic [6:0] SEG_SEVEN = 7'h70;
  localparam logic [6:0] SEG_BLANK = 7'h00;
  localparam logic [7:0] MARKER    = 8'hFE;

  function automatic logic [7:0] seg_decode(input logic [7:0] b);
    logic [6:0] m;
    logic [7:0] c;
    m = b[6:0];
    unique case (m)
      7'h7E:   c = "0";
      7'h30:   c = "1";
      7'h6D:   c = "2";
      7'h79:   c = "3";
      7'h33:   c = "4";
      7'h5B:   c = "5";
      7'h5F:   c = "6";
      7'h70:   c = "7";
      7'h7F:   c = "8";
      7'h7B:   c = "9";
      7'h00:   c = " ";
      7'h37:   c = "H";
      7'h0E:   c = "L";
      7'h67:   c = "P";
      7'h4F:   c = "E";
      7'h01:   c = "-";
      7'h03:   c = "-";
      7'h0D:   c = "c";
      7'h05:   c = "r";
      7'h1D:   c = "o";
      default: c = CH_QUERY;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/ssfd_front.sv
// Front end: accepts display bytes, applies the gap timeout and assembles complete frames.
module ssfd_front #(
  parameter int unsigned FRAME_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ssfd_pkg::in_t     in_data,
  input  logic [7:0]        gap_limit_ms,
  input  logic              queue_full,
  output logic              push,
  output logic [63:0]       push_frame
);
  import ssfd_pkg::*;

  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_BYTES - 1);

  logic [7:0]       byte_store [MAX_BYTES];
  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] byte_count_next;
  logic [31:0]      last_arrival;
  logic [CNT_W-1:0] pos;
  logic [31:0]      elapsed;
  logic             accept;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;
  assign elapsed  = in_data.now_ms - last_arrival;

  always_comb begin
    if (byte_count != '0 && elapsed > {24'd0, gap_limit_ms}) begin
      pos = '0;
    end else begin
      pos = byte_count;
    end
    push = accept && (pos == LAST_POS);
    byte_count_next = push ? '0 : pos + CNT_W'(1);
  end

  always_comb begin
    push_frame = '0;
    for (int k = 0; k < MAX_BYTES; k++) begin
      if (k == FRAME_BYTES - 1) begin
        push_frame[63 - 8*k -: 8] = in_data.data_byte;
      end else if (k < FRAME_BYTES - 1) begin
        push_frame[63 - 8*k -: 8] = byte_store[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      last_arrival <= '0;
    end else if (accept) begin
      byte_count   <= byte_count_next;
      last_arrival <= in_data.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_store[pos[2:0]] <= in_data.data_byte;
    end
  end

endmodule

// File: rtl/ssfd_fifo.sv
// Two-entry frame queue between the front end and the decode back end.
module ssfd_fifo (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [63:0] push_frame,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output logic [63:0] head_frame
);
  import ssfd_pkg::*;

  localparam int unsigned DEPTH = 2;

  logic [63:0] mem [DEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full       = (count == 2'(DEPTH));
  assign head_valid = (count != 2'd0);
  assign head_frame = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_frame;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("frame queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("frame queue read while empty");

endmodule

// File: rtl/ssfd_back.sv
// Back end: walks one queued frame a byte per cycle, classifies it and registers the result.
module ssfd_back #(
  parameter int unsigned FRAME_BYTES = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  logic [63:0]    head_frame,
  output logic           pop,
  input  logic [9:0]     temp_low_limit,
  input  logic [9:0]     temp_high_limit,
  output logic           out_valid,
  input  logic           out_stall,
  output ssfd_pkg::out_t out_data
);
  import ssfd_pkg::*;

  localparam logic [CNT_W-1:0] NBYTES = CNT_W'(FRAME_BYTES);

  back_state_t state;
  back_state_t state_next;
  logic        load_out;

  logic [63:0] frame_sh;
  logic [63:0] raw_keep;
  logic [63:0] text;
  logic [2:0]  idx;
  logic [3:0]  n;
  logic [7:0]  strip [3];
  logic        all_dig;
  logic [9:0]  temp_acc;
  logic [3:0]  confirmed;

  logic [63:0] previous_frame;
  logic        frame_seen;
  logic [9:0]  held_temperature;
  logic        held_temp_valid;
  logic [2:0]  previous_class;

  logic        in_frame;
  logic [7:0]  cur_byte;
  logic [7:0]  cur_char;
  logic [6:0]  cur_seg;
  logic        is_digit;

  logic [2:0]  cls;
  logic        oor;
  logic        tchg;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:   if (head_valid) state_next = B_WALK;
      B_WALK:   if (idx == 3'd7) state_next = B_FINISH;
      B_FINISH: if (!out_valid || !out_stall) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state == B_IDLE) && head_valid;
    load_out = (state == B_FINISH) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_frame = ({1'b0, idx} < NBYTES);
  assign cur_byte = frame_sh[63:56];
  assign cur_seg  = cur_byte[6:0];
  assign cur_char = in_frame ? seg_decode(cur_byte & SEG_MASK) : 8'h00;
  assign is_digit = (cur_char >= CH_ZERO) && (cur_char <= CH_NINE);

  always_ff @(posedge clk) begin
    if (pop) begin
      frame_sh  <= head_frame;
      raw_keep  <= head_frame;
      text      <= '0;
      idx       <= 3'd0;
      n         <= 4'd0;
      all_dig   <= 1'b1;
      temp_acc  <= 10'd0;
      confirmed <= 4'd0;
    end else if (state == B_WALK) begin
      frame_sh <= {frame_sh[55:0], 8'h00};
      text     <= {text[55:0], cur_char};
      idx      <= idx + 3'd1;
      if (in_frame) begin
        if (cur_seg == SEG_ONE || cur_seg == SEG_SEVEN || cur_seg == SEG_BLANK) begin
          confirmed <= confirmed + 4'd1;
        end
        if (cur_char != CH_SPACE) begin
          n <= n + 4'd1;
          if (n < 4'd3) begin
            strip[n[1:0]] <= cur_char;
          end
          if (is_digit) begin
            temp_acc <= 10'(temp_acc * 4'd10 + {6'd0, cur_char[3:0]});
          end else begin
            all_dig <= 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    oor  = 1'b0;
    tchg = 1'b0;
    if (all_dig && (n == 4'd2 || n == 4'd3)) begin
      cls  = CLASS_TEMP;
      oor  = (temp_acc < temp_low_limit) || (temp_acc > temp_high_limit);
      tchg = !held_temp_valid || (temp_acc != held_temperature);
    end else if (n == 4'd2 && strip[0] == CH_O && strip[1] == CH_H) begin
      cls = CLASS_OH;
    end else if (n == 4'd3 && strip[0] == CH_I && strip[1] == CH_C && strip[2] == CH_E) begin
      cls = CLASS_ICE;
    end else if ((n == 4'd2 || n == 4'd3) && strip[0] == CH_DASH && strip[1] == CH_DASH &&
                 (n == 4'd2 || strip[2] == CH_DASH)) begin
      cls = CLASS_STARTUP;
    end else if (n == 4'd0) begin
      cls = CLASS_BLANK;
    end else begin
      cls = CLASS_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_frame   <= '0;
      frame_seen       <= 1'b0;
      held_temperature <= '0;
      held_temp_valid  <= 1'b0;
      previous_class   <= CLASS_NONE;
      out_valid        <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid      <= 1'b1;
        previous_frame <= raw_keep;
        frame_seen     <= 1'b1;
        previous_class <= cls;
        if (tchg) begin
          held_temperature <= temp_acc;
          held_temp_valid  <= 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.display_text      <= text;
      out_data.raw_frame         <= raw_keep;
      out_data.display_class     <= cls;
      out_data.temperature       <= tchg ? temp_acc : held_temperature;
      out_data.temp_valid        <= tchg || held_temp_valid;
      out_data.temp_changed      <= tchg;
      out_data.class_changed     <= (cls != previous_class);
      out_data.frame_changed     <= !frame_seen || (raw_keep != previous_frame);
      out_data.match_count       <= confirmed;
      out_data.temp_out_of_range <= oor;
      out_data.marker_present    <= (raw_keep[63:56] == MARKER);
    end
  end

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == B_WALK && idx == 3'd7) |=> (state == B_FINISH))
    else $error("frame walk did not end after eight bytes");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == B_FINISH))
    else $error("result appeared outside the finish step");

  a_temp_change_consistent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.temp_changed) |->
      (out_data.temp_valid && out_data.display_class == CLASS_TEMP))
    else $error("temperature change flagged on a non-temperature frame");

endmodule

// File: rtl/seven_segment_frame_decoder.sv
// Top level of the seven-segment frame decoder: configuration registers and the three stages.
//
// Input channel: one beat per sniffed display byte with its arrival time in milliseconds.
// A beat is taken when in_valid is high and in_stall low. Bytes are accepted one per cycle;
// in_stall rises only while both frame queue entries are occupied.
// Every FRAME_BYTES-th byte closes a frame; a gap above the gap limit drops a partial frame.
// Output channel: one beat per completed frame, taken when out_valid is high and out_stall
// low. After the edge that takes the closing byte, the frame passes through the queue into
// the walker, which walks it a byte per cycle; then the result is registered.
// The back end decodes one frame at a time and pops the next frame from the queue only
// after it has loaded the result of the last one.
// While the receiver stalls, the result is held; the back end finishes its current frame
// and waits, the queue fills, and then the input stalls.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; index 0 is the
// gap limit, 1 the low and 2 the high temperature limit; index 3 is ignored.
// Synchronous reset restores the register defaults (1, 80, 120), empties the queue and
// clears the partial frame, held temperature and change history.
module seven_segment_frame_decoder #(
  parameter int unsigned FRAME_BYTES = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  ssfd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ssfd_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [9:0]     cfg_data
);
  import ssfd_pkg::*;

  logic [7:0]  gap_limit_ms;
  logic [9:0]  temp_low_limit;
  logic [9:0]  temp_high_limit;

  logic        queue_full;
  logic        push;
  logic [63:0] push_frame;
  logic        pop;
  logic        head_valid;
  logic [63:0] head_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit_ms    <= 8'd1;
      temp_low_limit  <= 10'd80;
      temp_high_limit <= 10'd120;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_GAP: gap_limit_ms    <= cfg_data[7:0];
        REG_TEMP_LOW:  temp_low_limit  <= cfg_data;
        REG_TEMP_HIGH: temp_high_limit <= cfg_data;
        default:       gap_limit_ms    <= gap_limit_ms;
      endcase
    end
  end

  ssfd_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .gap_limit_ms (gap_limit_ms),
    .queue_full   (queue_full),
    .push         (push),
    .push_frame   (push_frame)
  );

  ssfd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_frame (head_frame)
  );

  ssfd_back #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head_frame      (head_frame),
    .pop             (pop),
    .temp_low_limit  (temp_low_limit),
    .temp_high_limit (temp_high_limit),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data)
  );

endmodule

// File: tb/sv/tb_seven_segment_frame_decoder.sv
// Testbench for the seven-segment frame decoder: random display bytes against a frame predictor.
module tb_seven_segment_frame_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import ssfd_pkg::*;

  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;

  class frame_checker;
    logic [7:0]  gap_limit;
    logic [9:0]  low_limit;
    logic [9:0]  high_limit;
    logic [7:0]  frame_bytes [8];
    int unsigned fill;
    logic [31:0] last_ms;
    logic [63:0] prev_raw;
    bit          seen;
    logic [9:0]  held_temp;
    bit          held_ok;
    logic [2:0]  prev_class;
    out_t        awaited_frames [$];
    int          errors;
    int          frames_done;
    int          temp_moves;
    int          out_of_range;
    int          markers;
    int          repeats;
    int          per_class [8];

    function new();
      gap_limit  = 8'd1;
      low_limit  = 10'd80;
      high_limit = 10'd120;
      fill       = 0;
      last_ms    = '0;
      prev_raw   = '0;
      seen       = 1'b0;
      held_temp  = '0;
      held_ok    = 1'b0;
      prev_class = CLASS_NONE;
      errors     = 0;
      frames_done  = 0;
      temp_moves   = 0;
      out_of_range = 0;
      markers      = 0;
      repeats      = 0;
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
      foreach (per_class[i]) per_class[i] = 0;
    endfunction

    function logic [7:0] glyph_of(logic [6:0] p);
      case (p)
        7'h7E: return "0";
        7'h30: return "1";
        7'h6D: return "2";
        7'h79: return "3";
        7'h33: return "4";
        7'h5B: return "5";
        7'h5F: return "6";
        7'h70: return "7";
        7'h7F: return "8";
        7'h7B: return "9";
        7'h00: return " ";
        7'h37: return "H";
        7'h0E: return "L";
        7'h67: return "P";
        7'h4F: return "E";
        7'h01, 7'h03: return "-";
        7'h0D: return "c";
        7'h05: return "r";
        7'h1D: return "o";
        default: return CH_QUERY;
      endcase
    endfunction

    function void write_reg(logic [1:0] idx, logic [9:0] val);
      case (idx)
        REG_FRAME_GAP: gap_limit  = val[7:0];
        REG_TEMP_LOW:  low_limit  = val;
        REG_TEMP_HIGH: high_limit = val;
        default: ;
      endcase
    endfunction

    function void note_byte(in_t beat);
      logic [31:0] elapsed;
      logic [7:0]  glyphs [8];
      logic [7:0]  g;
      logic [6:0]  m;
      int          kept;
      int          value;
      int          confirmed;
      bit          digits_only;
      out_t        want;
      elapsed = beat.now_ms - last_ms;
      if (fill > 0 && elapsed > {24'd0, gap_limit}) fill = 0;
      last_ms = beat.now_ms;
      frame_bytes[fill] = beat.data_byte;
      fill++;
      if (fill < MAX_BYTES) return;
      fill = 0;
      want = '0;
      kept = 0;
      value = 0;
      confirmed = 0;
      digits_only = 1'b1;
      foreach (glyphs[i]) glyphs[i] = '0;
      for (int i = 0; i < 8; i++) begin
        m = frame_bytes[i][6:0];
        g = glyph_of(m);
        want.display_text[63-8*i -: 8] = g;
        want.raw_frame[63-8*i -: 8]    = frame_bytes[i];
        if (m == SEG_ONE || m == SEG_SEVEN || m == SEG_BLANK) confirmed++;
        if (g != CH_SPACE) begin
          glyphs[kept] = g;
          kept++;
        end
      end
      for (int i = 0; i < kept; i++) begin
        if (glyphs[i] < CH_ZERO || glyphs[i] > CH_NINE) digits_only = 1'b0;
        else value = value * 10 + int'(glyphs[i] - CH_ZERO);
      end
      if (digits_only && kept >= 2 && kept <= 3) begin
        want.display_class = CLASS_TEMP;
        want.temp_out_of_range = (value < low_limit) || (value > high_limit);
        if (!held_ok || value != held_temp) begin
          want.temp_changed = 1'b1;
          held_temp = value[9:0];
          held_ok = 1'b1;
        end
      end else if (kept == 2 && glyphs[0] == CH_O && glyphs[1] == CH_H) begin
        want.display_class = CLASS_OH;
      end else if (kept == 3 && glyphs[0] == CH_I && glyphs[1] == CH_C &&
                   glyphs[2] == CH_E) begin
        want.display_class = CLASS_ICE;
      end else if ((kept == 2 || kept == 3) && glyphs[0] == CH_DASH && glyphs[1] == CH_DASH &&
                   (kept == 2 || glyphs[2] == CH_DASH)) begin
        want.display_class = CLASS_STARTUP;
      end else if (kept == 0) begin
        want.display_class = CLASS_BLANK;
      end else begin
        want.display_class = CLASS_UNKNOWN;
      end
      want.temperature     = held_temp;
      want.temp_valid      = held_ok;
      want.class_changed   = want.display_class != prev_class;
      want.frame_changed   = !seen || want.raw_frame != prev_raw;
      want.match_count     = confirmed[3:0];
      want.marker_present  = frame_bytes[0] == MARKER;
      prev_class = want.display_class;
      prev_raw   = want.raw_frame;
      seen       = 1'b1;
      awaited_frames.push_back(want);
    endfunction

    function int field_diff(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
        return 1;
      end
      return 0;
    endfunction

    function void check_frame(out_t got);
      out_t want;
      int   bad;
      if (awaited_frames.size() == 0) begin
        errors++;
        $display("%0t ns: result beat with no frame outstanding, got %h", $time, got);
        return;
      end
      want = awaited_frames.pop_front();
      frames_done++;
      per_class[want.display_class]++;
      if (want.temp_changed) temp_moves++;
      if (want.temp_out_of_range) out_of_range++;
      if (want.marker_present) markers++;
      if (!want.frame_changed) repeats++;
      bad = 0;
      bad += field_diff("display_text", want.display_text, got.display_text);
      bad += field_diff("raw_frame", want.raw_frame, got.raw_frame);
      bad += field_diff("display_class", 64'(want.display_class), 64'(got.display_class));
      bad += field_diff("temperature", 64'(want.temperature), 64'(got.temperature));
      bad += field_diff("temp_valid", 64'(want.temp_valid), 64'(got.temp_valid));
      bad += field_diff("temp_changed", 64'(want.temp_changed), 64'(got.temp_changed));
      bad += field_diff("class_changed", 64'(want.class_changed), 64'(got.class_changed));
      bad += field_diff("frame_changed", 64'(want.frame_changed), 64'(got.frame_changed));
      bad += field_diff("match_count", 64'(want.match_count), 64'(got.match_count));
      bad += field_diff("temp_out_of_range", 64'(want.temp_out_of_range),
                        64'(got.temp_out_of_range));
      bad += field_diff("marker_present", 64'(want.marker_present),
                        64'(got.marker_present));
      if (bad != 0) errors++;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [9:0] cfg_data;

  frame_checker sb;
  logic [31:0]  clock_ms;
  logic [63:0]  last_frame;
  bit           force_break;
  bit           in_idling;
  bit           out_idling;
  int           bytes_sent;
  int           cycles;

  seven_segment_frame_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with frames still outstanding.", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_frame(out_data);
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (out_idling && $urandom_range(0, 15) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] seg_code_of(int k);
    case (k)
      0: return 8'h7E;
      1: return 8'h30;
      2: return 8'h6D;
      3: return 8'h79;
      4: return 8'h33;
      5: return 8'h5B;
      6: return 8'h5F;
      7: return 8'h70;
      8: return 8'h7F;
      9: return 8'h7B;
      10: return 8'h00;
      11: return 8'h37;
      12: return 8'h0E;
      13: return 8'h67;
      14: return 8'h4F;
      15: return 8'h01;
      16: return 8'h03;
      17: return 8'h0D;
      18: return 8'h05;
      default: return 8'h1D;
    endcase
  endfunction

  function automatic logic [7:0] with_point(logic [7:0] p);
    return ($urandom_range(0, 3) == 0) ? (p | 8'h80) : p;
  endfunction

  // Spreads the leading glyphs of seq over the eight positions in order, blanks elsewhere.
  function automatic logic [63:0] spread(logic [63:0] seq, int count);
    logic [63:0] f;
    int          left;
    int          k;
    f = '0;
    left = count;
    k = 0;
    for (int i = 0; i < 8; i++) begin
      if (left > 0 && $urandom_range(1, 8 - i) <= left) begin
        f[63-8*i -: 8] = with_point(seq[63-8*k -: 8]);
        k++;
        left--;
      end else begin
        f[63-8*i -: 8] = with_point(8'h00);
      end
    end
    return f;
  endfunction

  function automatic logic [63:0] temp_frame();
    logic [63:0] seq;
    int          v;
    int          digits;
    int          scale;
    case ($urandom_range(0, 7))
      0: v = int'(sb.low_limit) - 1;
      1: v = int'(sb.low_limit);
      2: v = int'(sb.high_limit);
      3: v = int'(sb.high_limit) + 1;
      4: v = int'(sb.held_temp);
      5: v = $urandom_range(0, 99);
      default: v = $urandom_range(0, 999);
    endcase
    if (v < 0) v = 0;
    if (v > 999) v = 999;
    digits = (v < 100 && $urandom_range(0, 1) == 1) ? 2 : 3;
    if ($urandom_range(0, 15) == 0) digits = $urandom_range(0, 1) ? 1 : 4;
    scale = 1;
    for (int j = 1; j < digits; j++) scale = scale * 10;
    seq = '0;
    for (int k = 0; k < digits; k++) begin
      seq[63-8*k -: 8] = seg_code_of((v / scale) % 10);
      scale = scale / 10;
    end
    return spread(seq, digits);
  endfunction

  function automatic logic [63:0] startup_frame();
    logic [63:0] seq;
    int          n;
    n = $urandom_range(2, 3);
    if ($urandom_range(0, 7) == 0) n = $urandom_range(0, 1) ? 1 : 4;
    seq = '0;
    for (int k = 0; k < n; k++) seq[63-8*k -: 8] = $urandom_range(0, 1) ? 8'h01 : 8'h03;
    if ($urandom_range(0, 3) == 0) seq[63-8*(n-1) -: 8] = seg_code_of($urandom_range(0, 19));
    return spread(seq, n);
  endfunction

  function automatic logic [63:0] glyph_frame();
    logic [63:0] f;
    for (int i = 0; i < 8; i++) f[63-8*i -: 8] = with_point(seg_code_of($urandom_range(0, 19)));
    return f;
  endfunction

  function automatic logic [63:0] pick_frame();
    logic [63:0] f;
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5: f = temp_frame();
      6, 7: f = startup_frame();
      8: f = spread('0, 0);
      9, 10, 15: f = glyph_frame();
      11: f = {$urandom, $urandom};
      12: begin
        f = $urandom_range(0, 1) ? temp_frame() : glyph_frame();
        f[63:56] = MARKER;
      end
      default: f = last_frame;
    endcase
    return f;
  endfunction

  function automatic int unsigned pick_delta();
    int unsigned gap;
    gap = sb.gap_limit;
    if (force_break) begin
      force_break = 1'b0;
      return $urandom_range(0, 1) ? gap + 1 : $urandom_range(32'hFFFF_FFFF, gap + 1);
    end
    if ($urandom_range(0, 7) == 0) return gap;
    return $urandom_range(gap, 0);
  endfunction

  task automatic push_byte(logic [7:0] b, int unsigned delta);
    in_t beat;
    clock_ms = clock_ms + delta;
    beat.data_byte = b;
    beat.now_ms = clock_ms;
    if (in_idling && $urandom_range(0, 11) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(beat);
    bytes_sent++;
  endtask

  task automatic send_frame(logic [63:0] f);
    for (int i = 0; i < 8; i++) push_byte(f[63-8*i -: 8], pick_delta());
    last_frame = f;
  endtask

  task automatic set_reg(logic [1:0] idx, logic [9:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.awaited_frames.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
  endtask

  task automatic run_phase(int budget);
    int start;
    int r;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      r = $urandom_range(0, 19);
      if (r < 2) begin
        // A partial frame cut short by a long pause.
        repeat ($urandom_range(1, 7)) push_byte(with_point(seg_code_of($urandom_range(0, 19))),
                                                pick_delta());
        force_break = 1'b1;
      end else if (r == 2) begin
        // Stray beats with no pause, so the following frames are taken out of step.
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), pick_delta());
      end
      if ($urandom_range(0, 9) == 0) clock_ms = $urandom;
      send_frame(pick_frame());
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_FRAME_GAP;
    cfg_data = '0;
    clock_ms = '0;
    last_frame = '0;
    force_break = 1'b0;
    in_idling = 1'b0;
    out_idling = 1'b0;
    bytes_sent = 0;
    cycles = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed frames at the reset settings: a temperature at the high limit, a startup
    // display with point bits set, a partial frame dropped by a pause, and a marker frame
    // whose arrival times wrap past the top of the counter.
    for (int i = 0; i < 8; i++) push_byte(8'(64'h0080_0000_00B0_6D7E >> (56 - 8 * i)), 1);
    for (int i = 0; i < 8; i++) push_byte(8'(64'h0183_8100_0080_0000 >> (56 - 8 * i)), i % 2);
    push_byte(8'h7F, 1);
    push_byte(8'h30, 1);
    push_byte(8'h70, 1);
    clock_ms = 32'hFFFF_FFFC;
    for (int i = 0; i < 8; i++) begin
      push_byte(8'(64'hFEFF_7F00_374F_0E67 >> (56 - 8 * i)), (i > 0) ? 1 : 0);
    end
    last_frame = 64'hFEFF_7F00_374F_0E67;
    settle();

    in_idling = 1'b1;
    out_idling = 1'b1;
    run_phase(250);
    settle();

    set_reg(REG_FRAME_GAP, 10'd0);
    set_reg(REG_TEMP_LOW, 10'd0);
    set_reg(REG_TEMP_HIGH, 10'd999);
    out_idling = 1'b0;
    run_phase(250);
    settle();

    set_reg(REG_FRAME_GAP, 10'd255);
    set_reg(REG_TEMP_LOW, 10'd999);
    set_reg(REG_TEMP_HIGH, 10'd0);
    out_idling = 1'b1;
    run_phase(250);
    settle();

    set_reg(REG_UNUSED, 10'($urandom_range(0, 1023)));
    set_reg(REG_FRAME_GAP, 10'd10);
    set_reg(REG_TEMP_LOW, 10'd100);
    set_reg(REG_TEMP_HIGH, 10'd100);
    in_idling = 1'b0;
    run_phase(250);
    settle();

    set_reg(REG_FRAME_GAP, 10'($urandom_range(1, 255)));
    set_reg(REG_TEMP_LOW, 10'($urandom_range(0, 999)));
    set_reg(REG_TEMP_HIGH, 10'($urandom_range(0, 999)));
    in_idling = 1'b1;
    run_phase(250);
    settle();

    set_reg(REG_FRAME_GAP, 10'd3);
    set_reg(REG_TEMP_LOW, 10'd80);
    set_reg(REG_TEMP_HIGH, 10'd120);
    in_idling = 1'b0;
    out_idling = 1'b0;
    run_phase(250);
    settle();

    if (sb.awaited_frames.size() != 0) begin
      sb.errors++;
      $display("%0t ns: %0d expected frames never arrived", $time, sb.awaited_frames.size());
    end
    $display("Sent %0d byte beats and checked %0d frames under six register settings.",
             bytes_sent, sb.frames_done);
    $write("Frames per class temp/startup/blank/unknown %0d/%0d/%0d/%0d; ",
           sb.per_class[CLASS_TEMP], sb.per_class[CLASS_STARTUP], sb.per_class[CLASS_BLANK],
           sb.per_class[CLASS_UNKNOWN]);
    $display("%0d new readings, %0d out of range, %0d markers, %0d repeats.",
             sb.temp_moves, sb.out_of_range, sb.markers, sb.repeats);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
